/* rtl/mts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned DefaultDepth = 64;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Shift control broadcast along a chain of cells.
  typedef struct packed {
    logic push;  // every cell takes its upper neighbor
    logic pop;   // every cell takes its lower neighbor
  } shift_t;

endpackage

/* rtl/min_tracking_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack
// Signed LIFO stack of STACK_DEPTH entries that also reports its minimum.
// ----------------------------------------------------------------------------
// Each item pushes (op 0) or pops (op 1) and yields one result item with the
// top, the minimum, an empty flag and a status after the operation; both read
// as 0 when the stack is empty. A push when full or a pop when empty changes
// nothing and is flagged. Data and minimums sit in two shift chains of cells
// with the top in cell 0, so each result reads only cell 0 and cell 1 plus
// the counts: one item per cycle unless stalled, with each result in the
// output register in the cycle after its item. Input is stalled only while a
// result waits and the output side stalls.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [0:0]           op_i,
  input  logic signed [31:0]   value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   stack_top_o,
  output logic signed [31:0]   min_value_o,
  output logic                 is_empty_o,
  output logic [1:0]           status_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic [CntW-1:0] val_cnt_d, val_cnt_q;
  logic [CntW-1:0] min_cnt_d, min_cnt_q;

  mts_pkg::data_t  vtop, vnext, mtop, mnext;
  mts_pkg::shift_t val_ctl, min_ctl;

  logic accept, is_full, is_void, push_ok, pop_ok, min_push, min_pop;

  logic              out_valid_q;
  mts_pkg::data_t    top_d, top_q, min_d, min_q;
  logic              empty_d, empty_q;
  mts_pkg::status_e  status_d, status_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full = (val_cnt_q == CntW'(STACK_DEPTH));
  assign is_void = (val_cnt_q == '0);

  assign push_ok  = accept && (op_i == mts_pkg::OP_PUSH) && !is_full;
  assign pop_ok   = accept && (op_i == mts_pkg::OP_POP) && !is_void;
  // Minimum chain never outgrows the data chain, so it cannot overflow.
  assign min_push = push_ok && ((min_cnt_q == '0) || (value_i <= mtop));
  assign min_pop  = pop_ok && (min_cnt_q != '0) && (vtop == mtop);

  assign val_ctl = '{push: push_ok, pop: pop_ok};
  assign min_ctl = '{push: min_push, pop: min_pop};

  mts_chain #(.Depth(STACK_DEPTH)) u_val_chain (
    .clk_i       (clk_i),
    .ctl_i       (val_ctl),
    .push_data_i (value_i),
    .top_o       (vtop),
    .next_o      (vnext)
  );

  mts_chain #(.Depth(STACK_DEPTH)) u_min_chain (
    .clk_i       (clk_i),
    .ctl_i       (min_ctl),
    .push_data_i (value_i),
    .top_o       (mtop),
    .next_o      (mnext)
  );

  always_comb begin
    val_cnt_d = val_cnt_q;
    min_cnt_d = min_cnt_q;
    if (push_ok) begin
      val_cnt_d = val_cnt_q + 1'b1;
    end else if (pop_ok) begin
      val_cnt_d = val_cnt_q - 1'b1;
    end
    if (min_push) begin
      min_cnt_d = min_cnt_q + 1'b1;
    end else if (min_pop) begin
      min_cnt_d = min_cnt_q - 1'b1;
    end
  end

  // Result reflects the state after this item.
  always_comb begin
    top_d    = '0;
    min_d    = '0;
    empty_d  = 1'b1;
    status_d = mts_pkg::ST_OK;
    if (op_i == mts_pkg::OP_PUSH) begin
      empty_d = 1'b0;
      if (is_full) begin
        status_d = mts_pkg::ST_FULL;
        top_d    = vtop;
        min_d    = mtop;
      end else begin
        top_d = value_i;
        min_d = min_push ? value_i : mtop;
      end
    end else if (is_void) begin
      status_d = mts_pkg::ST_EMPTY;
    end else if (val_cnt_q != CntW'(1)) begin
      empty_d = 1'b0;
      top_d   = vnext;
      min_d   = min_pop ? mnext : mtop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_cnt_q   <= '0;
      min_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      val_cnt_q <= val_cnt_d;
      min_cnt_q <= min_cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q    <= top_d;
      min_q    <= min_d;
      empty_q  <= empty_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign stack_top_o = top_q;
  assign min_value_o = min_q;
  assign is_empty_o  = empty_q;
  assign status_o    = status_q;

endmodule

/* rtl/mts_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_cell
// One stack slot: loads from the neighbor above on push, below on pop.
// ----------------------------------------------------------------------------
module mts_cell (
  input  logic           clk_i,
  input  mts_pkg::shift_t ctl_i,
  input  mts_pkg::data_t  up_i,
  input  mts_pkg::data_t  dn_i,
  output mts_pkg::data_t  q_o
);

  mts_pkg::data_t data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = up_i;
    end else if (ctl_i.pop) begin
      data_d = dn_i;
    end
  end

  // Slot contents carry no reset; only slots below the count are ever read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

/* rtl/mts_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_chain
// Row of stack cells; cell 0 is the top, data moves one cell per shift.
// ----------------------------------------------------------------------------
module mts_chain #(
  parameter int unsigned Depth = mts_pkg::DefaultDepth
) (
  input  logic            clk_i,
  input  mts_pkg::shift_t ctl_i,
  input  mts_pkg::data_t  push_data_i,
  output mts_pkg::data_t  top_o,
  output mts_pkg::data_t  next_o
);

  mts_pkg::data_t cell_q [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    mts_pkg::data_t up, dn;

    if (i == 0) begin : g_first
      assign up = push_data_i;
    end else begin : g_mid_up
      assign up = cell_q[i-1];
    end

    // Bottom cell refills from itself on pop; that slot is beyond the count.
    if (i == Depth - 1) begin : g_last
      assign dn = cell_q[i];
    end else begin : g_mid_dn
      assign dn = cell_q[i+1];
    end

    mts_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl_i),
      .up_i  (up),
      .dn_i  (dn),
      .q_o   (cell_q[i])
    );
  end

  assign top_o  = cell_q[0];
  assign next_o = cell_q[1];

endmodule

/* rtl/mts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the minimum tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [0:0]         op_i,
  input logic signed [31:0] value_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] stack_top_o,
  input logic signed [31:0] min_value_o,
  input logic               is_empty_o,
  input logic [1:0]         status_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every accepted item shows a result in the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // Empty stack reports zero top and minimum.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (stack_top_o == '0) && (min_value_o == '0))
    else $error("empty result with nonzero top or minimum");

  // Minimum never exceeds the top.
  a_min_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> (min_value_o <= stack_top_o))
    else $error("minimum above top of stack");

  // An ignored pop leaves the stack empty; a full push never does.
  a_status_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != 2'(mts_pkg::ST_OK)) |->
      (is_empty_o == (status_o == 2'(mts_pkg::ST_EMPTY))))
    else $error("status disagrees with empty flag");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

/* verif/min_tracking_stack_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Self-checking bench for the signed stack with running minimum.
// ----------------------------------------------------------------------------
// A short table of push and pop items covers the corners: pop on an empty
// stack, the largest and smallest values, and a duplicate of the minimum.
// Random runs of push-heavy, pop-heavy and mixed items then repeatedly fill
// and drain the stack. Every accepted item is run through a local stack model
// and each result item is compared field by field. Both handshake sides idle
// at random in the first two of three phases. A long output hold-off backs up
// the pipeline so that the input stalls.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;

  localparam int Depth       = int'(mts_pkg::DefaultDepth);
  localparam int RandomItems = 1250;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 400;

  typedef struct {
    mts_pkg::data_t   top;
    mts_pkg::data_t   minv;
    logic             empty;
    mts_pkg::status_e status;
  } result_t;

  typedef struct {
    mts_pkg::op_e   op;
    mts_pkg::data_t value;
    bit             fixed;
    result_t        want;
  } row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  logic [0:0]     op_i;
  mts_pkg::data_t value_i;
  logic           out_valid_o;
  logic           out_stall_i;
  mts_pkg::data_t stack_top_o;
  mts_pkg::data_t min_value_o;
  logic           is_empty_o;
  logic [1:0]     status_o;

  min_tracking_stack #(
    .STACK_DEPTH(Depth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stack_top_o(stack_top_o),
    .min_value_o(min_value_o),
    .is_empty_o (is_empty_o),
    .status_o   (status_o)
  );

  // local copy of both stacks
  mts_pkg::data_t data_stack [Depth];
  mts_pkg::data_t min_stack  [Depth];
  int      data_count;
  int      min_count;

  result_t awaited_results[$];
  row_t    directed[$];

  int      mismatches;
  int      results_seen;
  int      cycles;
  int      tx_idle_pct;
  int      rx_idle_pct;
  bit      hold_armed;
  int      push_items;
  int      pop_items;
  int      full_refusals;
  int      empty_refusals;
  int      deepest_data;
  int      deepest_min;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t stack_apply(mts_pkg::op_e op, mts_pkg::data_t v);
    result_t r;
    r.status = mts_pkg::ST_OK;
    if (op == mts_pkg::OP_PUSH) begin
      push_items++;
      if (data_count >= Depth) begin
        r.status = mts_pkg::ST_FULL;
        full_refusals++;
      end else begin
        data_stack[data_count] = v;
        data_count++;
        if (min_count == 0 || v <= min_stack[min_count-1]) begin
          min_stack[min_count] = v;
          min_count++;
        end
      end
    end else begin
      pop_items++;
      if (data_count == 0) begin
        r.status = mts_pkg::ST_EMPTY;
        empty_refusals++;
      end else begin
        if (min_count > 0 && data_stack[data_count-1] == min_stack[min_count-1]) begin
          min_count--;
        end
        data_count--;
      end
    end
    if (data_count > deepest_data) deepest_data = data_count;
    if (min_count > deepest_min) deepest_min = min_count;
    if (data_count == 0) begin
      r.top   = '0;
      r.minv  = '0;
      r.empty = 1'b1;
    end else begin
      r.top   = data_stack[data_count-1];
      r.minv  = min_stack[min_count-1];
      r.empty = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d, %s: got %h, want %h", results_seen, what, got,
             want);
  endtask

  task automatic add_row(mts_pkg::op_e op, mts_pkg::data_t v, bit fixed,
                         mts_pkg::data_t t = '0, mts_pkg::data_t m = '0,
                         logic e = 1'b0, mts_pkg::status_e s = mts_pkg::ST_OK);
    row_t r;
    r.op          = op;
    r.value       = v;
    r.fixed       = fixed;
    r.want.top    = t;
    r.want.minv   = m;
    r.want.empty  = e;
    r.want.status = s;
    directed.insert(directed.size(), r);
  endtask

  // called just after a rising edge; returns at the edge that accepts the item
  task automatic send_item(mts_pkg::op_e op, mts_pkg::data_t v, bit fixed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    predicted = stack_apply(op, v);
    awaited_results.insert(awaited_results.size(), fixed ? want : predicted);
  endtask

  function automatic mts_pkg::data_t pick_value();
    int             k;
    mts_pkg::data_t v;
    k = $urandom_range(99);
    if (k < 25) begin
      // narrow range so equal values and minimum ties are common
      k = $urandom_range(6);
      v = mts_pkg::data_t'(k - 3);
    end else if (k < 40) begin
      case ($urandom_range(3))
        0:       v = 32'sh7fffffff;
        1:       v = 32'sh80000000;
        2:       v = 32'sh00000000;
        default: v = 32'shffffffff;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // result side: random stalls, plus one long hold-off in the last phase
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_armed && !hold_done) begin
        hold_done   = 1'b1;
        hold_left   = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", stack_top_o, '0);
      end else begin
        want = awaited_results.pop_front();
        if (stack_top_o !== want.top) report_mismatch("stack_top", stack_top_o, want.top);
        if (min_value_o !== want.minv) report_mismatch("min_value", min_value_o, want.minv);
        if (is_empty_o !== want.empty) begin
          report_mismatch("is_empty", 32'(is_empty_o), 32'(want.empty));
        end
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("min_tracking_stack_tb: timed out after %0d cycles", cycles);
    $display("min_tracking_stack_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    result_t      none;
    mts_pkg::op_e op;
    int           run_left;
    int           push_pct;

    none        = '{default: '0, status: mts_pkg::ST_OK};
    run_left    = 0;
    push_pct    = 50;
    mismatches  = 0;
    data_count  = 0;
    min_count   = 0;
    hold_armed  = 1'b0;
    tx_idle_pct = 6;
    rx_idle_pct = 81;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    op_i        <= mts_pkg::OP_PUSH;
    value_i     <= '0;

    // corners first: the expected result is written out where it is obvious
    add_row(mts_pkg::OP_POP,  32'sd0,        1, '0, '0, 1'b1, mts_pkg::ST_EMPTY);
    add_row(mts_pkg::OP_PUSH, 32'sh7fffffff, 1, 32'sh7fffffff, 32'sh7fffffff, 1'b0,
            mts_pkg::ST_OK);
    add_row(mts_pkg::OP_PUSH, 32'sh80000000, 1, 32'sh80000000, 32'sh80000000, 1'b0,
            mts_pkg::ST_OK);
    add_row(mts_pkg::OP_PUSH, 32'sh80000000, 1, 32'sh80000000, 32'sh80000000, 1'b0,
            mts_pkg::ST_OK);
    // the duplicate minimum must survive one pop
    add_row(mts_pkg::OP_POP,  32'shffffffff, 1, 32'sh80000000, 32'sh80000000, 1'b0,
            mts_pkg::ST_OK);
    add_row(mts_pkg::OP_POP,  32'sd0,        1, 32'sh7fffffff, 32'sh7fffffff, 1'b0,
            mts_pkg::ST_OK);
    add_row(mts_pkg::OP_POP,  32'sd0,        1, '0, '0, 1'b1, mts_pkg::ST_OK);
    add_row(mts_pkg::OP_POP,  32'sh5a5a5a5a, 1, '0, '0, 1'b1, mts_pkg::ST_EMPTY);
    add_row(mts_pkg::OP_PUSH, 32'sd5,        0);
    add_row(mts_pkg::OP_PUSH, 32'sd5,        0);
    add_row(mts_pkg::OP_PUSH, 32'sd3,        0);
    add_row(mts_pkg::OP_PUSH, 32'sd3,        0);
    add_row(mts_pkg::OP_PUSH, 32'sd7,        0);
    add_row(mts_pkg::OP_PUSH, 32'shffffffff, 0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_PUSH, 32'sd0,        0);
    add_row(mts_pkg::OP_PUSH, 32'shffffffff, 0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);
    add_row(mts_pkg::OP_POP,  32'sd0,        0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].value, directed[i].fixed, directed[i].want);
    end

    // runs of mostly pushes, mostly pops or a mix keep hitting full and empty
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) begin
        tx_idle_pct = 81;
        rx_idle_pct = 6;
      end
      if (i == 2 * RandomItems / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_armed  = 1'b1;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(120, 20);
        case ($urandom_range(2))
          0:       push_pct = 90;
          1:       push_pct = 12;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      op = ($urandom_range(99) < push_pct) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP;
      send_item(op, pick_value(), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("min_tracking_stack_tb: %0d pushes and %0d pops, %0d pushes refused when full,",
             push_items, pop_items, full_refusals);
    $display("min_tracking_stack_tb: %0d pops refused when empty, depth %0d of %0d, min depth %0d",
             empty_refusals, deepest_data, Depth, deepest_min);
    if (mismatches == 0) begin
      $display("min_tracking_stack_tb: done, clean");
    end else begin
      $display("min_tracking_stack_tb: done, errors");
    end
    $finish;
  end

endmodule
